>>> sv/tts_pkg.sv
package tts_pkg;

    localparam int TAPE_CELLS = 1024;
    localparam int ADDR_W     = $clog2(TAPE_CELLS);
    localparam int POS_W      = 10;
    localparam int SYM_W      = 8;
    localparam int IDX_W      = 9;

    typedef logic [ADDR_W-1:0]       t_addr;
    typedef logic [SYM_W-1:0]        t_sym;
    typedef logic signed [POS_W-1:0] t_pos;

    localparam t_sym  BLANK_SYM = t_sym'(95);
    localparam t_pos  POS_MIN   = t_pos'(-(TAPE_CELLS / 2));
    localparam t_pos  POS_MAX   = t_pos'(TAPE_CELLS / 2 - 1);
    localparam t_addr HALF_ADDR = t_addr'(TAPE_CELLS / 2);
    localparam t_addr LAST_ADDR = t_addr'(TAPE_CELLS - 1);

    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0,
        REQ_STEP = 2'd1,
        REQ_TRIM = 2'd2,
        REQ_NONE = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        DIR_STAY  = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_RIGHT = 2'd2,
        DIR_NONE  = 2'd3
    } t_dir;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_TRIM_LO_RD,
        S_TRIM_LO_CK,
        S_TRIM_HI_RD,
        S_TRIM_HI_CK,
        S_HEAD_RD,
        S_FIN
    } t_state;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_sym  wdata;
        logic  re;
        t_addr raddr;
    } t_mem_req;

    function automatic t_addr cell_addr(input t_pos pos);
        return t_addr'(pos) + HALF_ADDR;
    endfunction

endpackage

>>> sv/tts_tape_ram.sv
module tts_tape_ram (
    input  logic               i_clk,
    input  tts_pkg::t_mem_req  i_req,
    output tts_pkg::t_sym      o_rdata
);

    tts_pkg::t_sym r_mem [tts_pkg::TAPE_CELLS];
    tts_pkg::t_sym r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/tts_ctrl.sv
module tts_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_req_type,
    input  tts_pkg::t_sym               i_symbol,
    input  logic                        i_write_enable,
    input  logic [1:0]                  i_move_dir,
    input  logic [tts_pkg::IDX_W-1:0]   i_load_index,
    input  logic                        i_load_last,
    output logic                        o_valid,
    input  logic                        i_ready,
    output tts_pkg::t_sym               o_read_symbol,
    output tts_pkg::t_pos               o_position,
    output tts_pkg::t_pos               o_range_low,
    output tts_pkg::t_pos               o_range_high,
    output logic                        o_bound_hit,
    output tts_pkg::t_mem_req           o_mem_req,
    input  tts_pkg::t_sym               i_mem_rdata
);

    tts_pkg::t_state r_state, n_state;
    tts_pkg::t_addr  r_clr, n_clr;
    tts_pkg::t_pos   r_head, n_head;
    tts_pkg::t_pos   r_low, n_low;
    tts_pkg::t_pos   r_high, n_high;
    logic            r_fwd, n_fwd;
    tts_pkg::t_sym   r_fwd_sym, n_fwd_sym;
    logic            r_hit, n_hit;
    logic            r_o_valid;
    tts_pkg::t_sym   r_o_sym;
    tts_pkg::t_pos   r_o_pos, r_o_low, r_o_high;
    logic            r_o_hit;

    logic            accept;
    logic            out_free;
    logic            lo_open, hi_open;
    logic            is_blank;
    tts_pkg::t_req   req;
    tts_pkg::t_dir   dir;
    tts_pkg::t_pos   load_pos;
    logic            load_hit;
    tts_pkg::t_pos   step_head;
    logic            step_hit;
    tts_pkg::t_sym   result_sym;

    assign req      = tts_pkg::t_req'(i_req_type);
    assign dir      = tts_pkg::t_dir'(i_move_dir);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_o_valid || i_ready;
    assign lo_open  = r_low < r_head;
    assign hi_open  = r_high > r_head;
    assign is_blank = i_mem_rdata == tts_pkg::BLANK_SYM;
    assign result_sym = r_fwd ? r_fwd_sym : i_mem_rdata;

    always_comb begin
        load_pos = tts_pkg::t_pos'({1'b0, i_load_index});
        load_hit = load_pos > tts_pkg::POS_MAX;
        if (load_hit) begin
            load_pos = tts_pkg::POS_MAX;
        end
    end

    always_comb begin
        step_head = r_head;
        step_hit  = 1'b0;
        unique case (dir)
            tts_pkg::DIR_LEFT: begin
                if (r_head != tts_pkg::POS_MIN) begin
                    step_head = r_head - tts_pkg::t_pos'(1);
                end else begin
                    step_hit = 1'b1;
                end
            end
            tts_pkg::DIR_RIGHT: begin
                if (r_head != tts_pkg::POS_MAX) begin
                    step_head = r_head + tts_pkg::t_pos'(1);
                end else begin
                    step_hit = 1'b1;
                end
            end
            tts_pkg::DIR_STAY, tts_pkg::DIR_NONE: begin
                step_head = r_head;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tts_pkg::S_CLEAR: begin
                if (r_clr == tts_pkg::LAST_ADDR) begin
                    n_state = tts_pkg::S_IDLE;
                end
            end
            tts_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = (req == tts_pkg::REQ_TRIM) ? tts_pkg::S_TRIM_LO_RD
                                                         : tts_pkg::S_FIN;
                end
            end
            tts_pkg::S_TRIM_LO_RD: begin
                n_state = lo_open ? tts_pkg::S_TRIM_LO_CK : tts_pkg::S_TRIM_HI_RD;
            end
            tts_pkg::S_TRIM_LO_CK: begin
                n_state = is_blank ? tts_pkg::S_TRIM_LO_RD : tts_pkg::S_TRIM_HI_RD;
            end
            tts_pkg::S_TRIM_HI_RD: begin
                n_state = hi_open ? tts_pkg::S_TRIM_HI_CK : tts_pkg::S_FIN;
            end
            tts_pkg::S_TRIM_HI_CK: begin
                n_state = is_blank ? tts_pkg::S_TRIM_HI_RD : tts_pkg::S_HEAD_RD;
            end
            tts_pkg::S_HEAD_RD: begin
                n_state = tts_pkg::S_FIN;
            end
            tts_pkg::S_FIN: begin
                if (out_free) begin
                    n_state = tts_pkg::S_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        o_ready   = 1'b0;
        o_mem_req = '0;
        unique case (r_state)
            tts_pkg::S_CLEAR: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_clr;
                o_mem_req.wdata = tts_pkg::BLANK_SYM;
            end
            tts_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    unique case (req)
                        tts_pkg::REQ_LOAD: begin
                            o_mem_req.we    = !load_hit;
                            o_mem_req.waddr = tts_pkg::cell_addr(load_pos);
                            o_mem_req.wdata = i_symbol;
                            o_mem_req.re    = 1'b1;
                            o_mem_req.raddr = tts_pkg::cell_addr('0);
                        end
                        tts_pkg::REQ_STEP: begin
                            o_mem_req.we    = i_write_enable;
                            o_mem_req.waddr = tts_pkg::cell_addr(r_head);
                            o_mem_req.wdata = i_symbol;
                            o_mem_req.re    = 1'b1;
                            o_mem_req.raddr = tts_pkg::cell_addr(step_head);
                        end
                        tts_pkg::REQ_TRIM: begin
                            o_mem_req.re = 1'b0;
                        end
                        tts_pkg::REQ_NONE: begin
                            o_mem_req.re    = 1'b1;
                            o_mem_req.raddr = tts_pkg::cell_addr(r_head);
                        end
                    endcase
                end
            end
            tts_pkg::S_TRIM_LO_RD: begin
                o_mem_req.re    = lo_open;
                o_mem_req.raddr = tts_pkg::cell_addr(r_low);
            end
            tts_pkg::S_TRIM_HI_RD: begin
                o_mem_req.re    = 1'b1;
                o_mem_req.raddr = hi_open ? tts_pkg::cell_addr(r_high)
                                          : tts_pkg::cell_addr(r_head);
            end
            tts_pkg::S_HEAD_RD: begin
                o_mem_req.re    = 1'b1;
                o_mem_req.raddr = tts_pkg::cell_addr(r_head);
            end
            tts_pkg::S_TRIM_LO_CK, tts_pkg::S_TRIM_HI_CK, tts_pkg::S_FIN: begin
                o_mem_req.re = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_clr     = r_clr;
        n_head    = r_head;
        n_low     = r_low;
        n_high    = r_high;
        n_fwd     = r_fwd;
        n_fwd_sym = r_fwd_sym;
        n_hit     = r_hit;
        if (r_state == tts_pkg::S_CLEAR) begin
            n_clr = r_clr + tts_pkg::t_addr'(1);
        end
        if (accept) begin
            n_fwd     = 1'b0;
            n_fwd_sym = i_symbol;
            n_hit     = 1'b0;
            unique case (req)
                tts_pkg::REQ_LOAD: begin
                    n_head = '0;
                    n_low  = '0;
                    n_high = i_load_last ? load_pos : '0;
                    n_fwd  = !load_hit && (load_pos == '0);
                    n_hit  = load_hit;
                end
                tts_pkg::REQ_STEP: begin
                    n_head = step_head;
                    n_low  = (step_head < r_low) ? step_head : r_low;
                    n_high = (step_head > r_high) ? step_head : r_high;
                    n_fwd  = i_write_enable && (step_head == r_head);
                    n_hit  = step_hit;
                end
                tts_pkg::REQ_TRIM, tts_pkg::REQ_NONE: begin
                    n_fwd = 1'b0;
                end
            endcase
        end
        if (r_state == tts_pkg::S_TRIM_LO_CK && is_blank) begin
            n_low = r_low + tts_pkg::t_pos'(1);
        end
        if (r_state == tts_pkg::S_TRIM_HI_CK && is_blank) begin
            n_high = r_high - tts_pkg::t_pos'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tts_pkg::S_CLEAR;
            r_clr     <= '0;
            r_head    <= '0;
            r_low     <= '0;
            r_high    <= '0;
            r_fwd     <= 1'b0;
            r_hit     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_head  <= n_head;
            r_low   <= n_low;
            r_high  <= n_high;
            r_fwd   <= n_fwd;
            r_hit   <= n_hit;
            if (r_state == tts_pkg::S_FIN && out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_sym <= n_fwd_sym;
        if (r_state == tts_pkg::S_FIN && out_free) begin
            r_o_sym  <= result_sym;
            r_o_pos  <= r_head;
            r_o_low  <= r_low;
            r_o_high <= r_high;
            r_o_hit  <= r_hit;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_read_symbol = r_o_sym;
    assign o_position    = r_o_pos;
    assign o_range_low   = r_o_low;
    assign o_range_high  = r_o_high;
    assign o_bound_hit   = r_o_hit;

    a_range_holds_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tts_pkg::S_IDLE |-> (r_low <= r_head && r_head <= r_high))
        else $error("used range does not hold the head");

    a_result_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_low <= r_o_pos && r_o_pos <= r_o_high))
        else $error("reported range does not hold the head");

    a_no_write_in_trim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tts_pkg::S_TRIM_LO_RD || r_state == tts_pkg::S_TRIM_LO_CK ||
         r_state == tts_pkg::S_TRIM_HI_RD || r_state == tts_pkg::S_TRIM_HI_CK ||
         r_state == tts_pkg::S_HEAD_RD) |-> !o_mem_req.we)
        else $error("tape written during a trim walk");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state != tts_pkg::S_IDLE)
        else $error("accepted word was not processed");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_state == tts_pkg::S_CLEAR) && r_state == tts_pkg::S_CLEAR |-> !r_o_valid)
        else $error("result produced during the clearing pass");

endmodule

>>> sv/two_way_tape_store_unit.sv
// A load, step or idle word goes from idle to a finish state, where its result is registered at the output.
// A trim word walks the low end of the used range up past blank cells, then the high end down,
// probing one cell at a time, and then reads the head cell before its result is registered.
// Each word holds off the next until its result is registered, and a stalled result holds it off too.
// Reset: synchronous, active low; afterward a clearing pass writes blank to all 1024 cells,
// one per cycle, and no word is accepted until the pass is through.
module two_way_tape_store_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_req_type,
    input  logic [7:0]                  i_symbol,
    input  logic                        i_write_enable,
    input  logic [1:0]                  i_move_dir,
    input  logic [8:0]                  i_load_index,
    input  logic                        i_load_last,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [7:0]                  o_read_symbol,
    output logic signed [9:0]           o_position,
    output logic signed [9:0]           o_range_low,
    output logic signed [9:0]           o_range_high,
    output logic                        o_bound_hit
);

    tts_pkg::t_mem_req mem_req;
    tts_pkg::t_sym     mem_rdata;

    tts_tape_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    tts_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_symbol       (i_symbol),
        .i_write_enable (i_write_enable),
        .i_move_dir     (i_move_dir),
        .i_load_index   (i_load_index),
        .i_load_last    (i_load_last),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_read_symbol  (o_read_symbol),
        .o_position     (o_position),
        .o_range_low    (o_range_low),
        .o_range_high   (o_range_high),
        .o_bound_hit    (o_bound_hit),
        .o_mem_req      (mem_req),
        .i_mem_rdata    (mem_rdata)
    );

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int            HALF_CELLS  = tts_pkg::TAPE_CELLS / 2;
    localparam int            CYCLE_LIMIT = 600000;
    localparam int            TAIL_CYCLES = 40;
    localparam tts_pkg::t_sym SYM_LEFT    = 8'h6C;
    localparam tts_pkg::t_sym SYM_RIGHT   = 8'h72;

    typedef struct packed {
        tts_pkg::t_req req;
        tts_pkg::t_sym sym;
        logic          we;
        tts_pkg::t_dir dir;
        logic [8:0]    idx;
        logic          last;
    } t_tape_word;

    typedef struct packed {
        tts_pkg::t_sym read_sym;
        tts_pkg::t_pos pos;
        tts_pkg::t_pos lo;
        tts_pkg::t_pos hi;
        logic          hit;
    } t_head_report;

    typedef struct {
        t_tape_word   w;
        bit           typed;
        t_head_report r;
    } t_directed_row;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic        o_ready;
    logic [1:0]  i_req_type     = '0;
    logic [7:0]  i_symbol       = '0;
    logic        i_write_enable = 1'b0;
    logic [1:0]  i_move_dir     = '0;
    logic [8:0]  i_load_index   = '0;
    logic        i_load_last    = 1'b0;
    logic        o_valid;
    logic        i_ready        = 1'b0;
    logic [7:0]  o_read_symbol;
    logic signed [9:0] o_position;
    logic signed [9:0] o_range_low;
    logic signed [9:0] o_range_high;
    logic        o_bound_hit;

    two_way_tape_store_unit dut (.*);

    tts_pkg::t_sym tape_image [tts_pkg::TAPE_CELLS];
    int            head_at;
    int            used_lo;
    int            used_hi;
    t_head_report  reports_due [$];
    t_directed_row directed_rows [$];
    int            sender_idle_pct = 0;
    int            recv_stall_pct  = 0;
    int            error_count     = 0;
    int            cycle_count     = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_head_report exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (reports_due.size() == 0) begin
                $error("result word with no expectation pending");
                error_count++;
            end else begin
                exp_r = reports_due.pop_front();
                if (o_read_symbol !== exp_r.read_sym) begin
                    $error("read_symbol: expected %0d, got %0d",
                           exp_r.read_sym, o_read_symbol);
                    error_count++;
                end
                if (o_position !== exp_r.pos) begin
                    $error("position: expected %0d, got %0d", exp_r.pos, o_position);
                    error_count++;
                end
                if (o_range_low !== exp_r.lo) begin
                    $error("range_low: expected %0d, got %0d", exp_r.lo, o_range_low);
                    error_count++;
                end
                if (o_range_high !== exp_r.hi) begin
                    $error("range_high: expected %0d, got %0d", exp_r.hi, o_range_high);
                    error_count++;
                end
                if (o_bound_hit !== exp_r.hit) begin
                    $error("bound_hit: expected %0d, got %0d", exp_r.hit, o_bound_hit);
                    error_count++;
                end
            end
        end
    end

    function automatic void widen_used();
        if (head_at < used_lo) used_lo = head_at;
        if (head_at > used_hi) used_hi = head_at;
    endfunction

    function automatic t_head_report tape_after(input t_tape_word w);
        t_head_report r;
        bit hit;
        int idx;
        hit = 1'b0;
        case (w.req)
            tts_pkg::REQ_LOAD: begin
                idx = int'(w.idx);
                if (idx > int'(tts_pkg::POS_MAX)) begin
                    idx = int'(tts_pkg::POS_MAX);
                    hit = 1'b1;
                end else begin
                    tape_image[idx + HALF_CELLS] = w.sym;
                end
                head_at = 0;
                used_lo = 0;
                used_hi = w.last ? idx : 0;
            end
            tts_pkg::REQ_STEP: begin
                if (w.we) tape_image[head_at + HALF_CELLS] = w.sym;
                widen_used();
                if (w.dir == tts_pkg::DIR_LEFT) begin
                    if (head_at > int'(tts_pkg::POS_MIN)) head_at--;
                    else hit = 1'b1;
                end else if (w.dir == tts_pkg::DIR_RIGHT) begin
                    if (head_at < int'(tts_pkg::POS_MAX)) head_at++;
                    else hit = 1'b1;
                end
            end
            tts_pkg::REQ_TRIM: begin
                widen_used();
                while (used_lo < head_at &&
                       tape_image[used_lo + HALF_CELLS] == tts_pkg::BLANK_SYM)
                    used_lo++;
                while (used_hi > head_at &&
                       tape_image[used_hi + HALF_CELLS] == tts_pkg::BLANK_SYM)
                    used_hi--;
            end
            default: ;
        endcase
        widen_used();
        r.read_sym = tape_image[head_at + HALF_CELLS];
        r.pos      = tts_pkg::t_pos'(head_at);
        r.lo       = tts_pkg::t_pos'(used_lo);
        r.hi       = tts_pkg::t_pos'(used_hi);
        r.hit      = hit;
        return r;
    endfunction

    function automatic t_tape_word mk_word(input tts_pkg::t_req req, input tts_pkg::t_sym sym,
                                           input logic we, input tts_pkg::t_dir dir,
                                           input logic [8:0] idx, input logic last);
        t_tape_word w;
        w.req  = req;
        w.sym  = sym;
        w.we   = we;
        w.dir  = dir;
        w.idx  = idx;
        w.last = last;
        return w;
    endfunction

    function automatic tts_pkg::t_sym pick_sym();
        int roll;
        roll = $urandom_range(9);
        if (roll < 4) return tts_pkg::BLANK_SYM;
        if (roll == 4) return SYM_LEFT;
        if (roll == 5) return SYM_RIGHT;
        return tts_pkg::t_sym'($urandom_range(255));
    endfunction

    function automatic void add_row(input t_tape_word w, input bit typed, input int rd,
                                    input int pos, input int lo, input int hi);
        t_directed_row row;
        row.w          = w;
        row.typed      = typed;
        row.r.read_sym = tts_pkg::t_sym'(rd);
        row.r.pos      = tts_pkg::t_pos'(pos);
        row.r.lo       = tts_pkg::t_pos'(lo);
        row.r.hi       = tts_pkg::t_pos'(hi);
        row.r.hit      = 1'b0;
        directed_rows  = {directed_rows, row};
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(input t_tape_word w, input bit typed = 1'b0,
                             input t_head_report typed_r = '0);
        t_head_report r;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_req_type     <= w.req;
        i_symbol       <= w.sym;
        i_write_enable <= w.we;
        i_move_dir     <= w.dir;
        i_load_index   <= w.idx;
        i_load_last    <= w.last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        r = tape_after(w);
        reports_due = {reports_due, (typed ? typed_r : r)};
    endtask

    task automatic drain_reports();
        i_valid <= 1'b0;
        while (reports_due.size() != 0) @(negedge i_clk);
    endtask

    task automatic random_phase(input int n_items);
        int sent;
        int n;
        int m;
        int base;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(9) < 7) begin
                n    = $urandom_range(1, 8);
                base = ($urandom_range(3) == 0) ? $urandom_range(500) : 0;
                for (int k = 0; k < n; k++) begin
                    send_word(mk_word(tts_pkg::REQ_LOAD, pick_sym(), 1'($urandom_range(1)),
                                      tts_pkg::t_dir'($urandom_range(3)), 9'(base + k),
                                      k == n - 1));
                    sent++;
                end
                m = $urandom_range(3, 30);
                for (int k = 0; k < m; k++) begin
                    if ($urandom_range(5) == 0) begin
                        send_word(mk_word(tts_pkg::REQ_TRIM, pick_sym(), 1'($urandom_range(1)),
                                          tts_pkg::t_dir'($urandom_range(3)),
                                          9'($urandom_range(511)), 1'($urandom_range(1))));
                    end else begin
                        send_word(mk_word(tts_pkg::REQ_STEP, pick_sym(),
                                          $urandom_range(2) != 0,
                                          ($urandom_range(9) == 0)
                                          ? tts_pkg::t_dir'($urandom_range(3))
                                          : tts_pkg::t_dir'($urandom_range(1, 2)),
                                          9'($urandom_range(511)), 1'($urandom_range(1))));
                    end
                    sent++;
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_word(mk_word(tts_pkg::t_req'($urandom_range(3)),
                                      tts_pkg::t_sym'($urandom_range(255)),
                                      1'($urandom_range(1)), tts_pkg::t_dir'($urandom_range(3)),
                                      9'($urandom_range(511)), ($urandom_range(4) == 0)));
                    sent++;
                end
            end
            if ($urandom_range(29) == 0) drain_reports();
        end
        drain_reports();
    endtask

    initial begin
        for (int k = 0; k < tts_pkg::TAPE_CELLS; k++) tape_image[k] = tts_pkg::BLANK_SYM;
        head_at = 0;
        used_lo = 0;
        used_hi = 0;

        add_row(mk_word(tts_pkg::REQ_NONE, 8'd0, 1'b0, tts_pkg::DIR_STAY, 9'd0, 1'b0),
                1, 95, 0, 0, 0);
        add_row(mk_word(tts_pkg::REQ_STEP, 8'd0, 1'b0, tts_pkg::DIR_LEFT, 9'd0, 1'b0),
                1, 95, -1, -1, 0);
        add_row(mk_word(tts_pkg::REQ_STEP, 8'd255, 1'b1, tts_pkg::DIR_STAY, 9'd0, 1'b0),
                1, 255, -1, -1, 0);
        add_row(mk_word(tts_pkg::REQ_STEP, 8'd0, 1'b1, tts_pkg::DIR_RIGHT, 9'd0, 1'b0),
                1, 95, 0, -1, 0);
        add_row(mk_word(tts_pkg::REQ_STEP, 8'd7, 1'b0, tts_pkg::DIR_NONE, 9'd0, 1'b0),
                1, 95, 0, -1, 0);
        add_row(mk_word(tts_pkg::REQ_TRIM, 8'd0, 1'b0, tts_pkg::DIR_STAY, 9'd0, 1'b0),
                1, 95, 0, -1, 0);
        add_row(mk_word(tts_pkg::REQ_LOAD, 8'd97, 1'b0, tts_pkg::DIR_STAY, 9'd0, 1'b0),
                1, 97, 0, 0, 0);
        add_row(mk_word(tts_pkg::REQ_LOAD, 8'h5A, 1'b1, tts_pkg::DIR_RIGHT, 9'd1, 1'b0),
                0, 0, 0, 0, 0);
        add_row(mk_word(tts_pkg::REQ_LOAD, 8'd255, 1'b0, tts_pkg::DIR_STAY, 9'd511, 1'b1),
                1, 97, 0, 0, 511);
        add_row(mk_word(tts_pkg::REQ_TRIM, 8'd0, 1'b0, tts_pkg::DIR_STAY, 9'd0, 1'b0),
                0, 0, 0, 0, 0);
        add_row(mk_word(tts_pkg::REQ_LOAD, tts_pkg::BLANK_SYM, 1'b0, tts_pkg::DIR_STAY,
                        9'd511, 1'b1), 0, 0, 0, 0, 0);
        add_row(mk_word(tts_pkg::REQ_TRIM, 8'd0, 1'b0, tts_pkg::DIR_STAY, 9'd0, 1'b0),
                0, 0, 0, 0, 0);
        add_row(mk_word(tts_pkg::REQ_STEP, SYM_RIGHT, 1'b1, tts_pkg::DIR_RIGHT, 9'd0, 1'b0),
                0, 0, 0, 0, 0);
        add_row(mk_word(tts_pkg::REQ_STEP, SYM_LEFT, 1'b1, tts_pkg::DIR_LEFT, 9'd0, 1'b0),
                0, 0, 0, 0, 0);
        add_row(mk_word(tts_pkg::REQ_STEP, tts_pkg::BLANK_SYM, 1'b1, tts_pkg::DIR_LEFT,
                        9'd0, 1'b0), 0, 0, 0, 0, 0);
        add_row(mk_word(tts_pkg::REQ_STEP, 8'd0, 1'b0, tts_pkg::DIR_LEFT, 9'd0, 1'b0),
                0, 0, 0, 0, 0);
        add_row(mk_word(tts_pkg::REQ_STEP, SYM_LEFT, 1'b1, tts_pkg::DIR_NONE, 9'd0, 1'b0),
                0, 0, 0, 0, 0);
        add_row(mk_word(tts_pkg::REQ_STEP, 8'd0, 1'b0, tts_pkg::DIR_RIGHT, 9'd0, 1'b0),
                0, 0, 0, 0, 0);
        add_row(mk_word(tts_pkg::REQ_STEP, 8'd0, 1'b0, tts_pkg::DIR_RIGHT, 9'd0, 1'b0),
                0, 0, 0, 0, 0);
        add_row(mk_word(tts_pkg::REQ_STEP, 8'd0, 1'b0, tts_pkg::DIR_RIGHT, 9'd0, 1'b0),
                0, 0, 0, 0, 0);
        add_row(mk_word(tts_pkg::REQ_TRIM, 8'd0, 1'b0, tts_pkg::DIR_STAY, 9'd0, 1'b0),
                0, 0, 0, 0, 0);
        add_row(mk_word(tts_pkg::REQ_NONE, 8'd255, 1'b1, tts_pkg::DIR_NONE, 9'd511, 1'b1),
                0, 0, 0, 0, 0);
        add_row(mk_word(tts_pkg::REQ_LOAD, 8'd0, 1'b1, tts_pkg::DIR_NONE, 9'd0, 1'b1),
                1, 0, 0, 0, 0);

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            send_word(directed_rows[k].w, directed_rows[k].typed, directed_rows[k].r);
        end

        // Walk the head into each tape bound from zero and trim the range after each walk.
        send_word(mk_word(tts_pkg::REQ_LOAD, pick_sym(), 1'b0, tts_pkg::DIR_STAY,
                          9'd0, 1'b0));
        repeat (514) begin
            send_word(mk_word(tts_pkg::REQ_STEP, pick_sym(), 1'($urandom_range(1)),
                              tts_pkg::DIR_LEFT, 9'($urandom_range(511)),
                              1'($urandom_range(1))));
        end
        send_word(mk_word(tts_pkg::REQ_TRIM, 8'd0, 1'b0, tts_pkg::DIR_STAY, 9'd0, 1'b0));
        send_word(mk_word(tts_pkg::REQ_LOAD, pick_sym(), 1'b0, tts_pkg::DIR_STAY,
                          9'd0, 1'b0));
        repeat (514) begin
            send_word(mk_word(tts_pkg::REQ_STEP, pick_sym(), 1'($urandom_range(1)),
                              tts_pkg::DIR_RIGHT, 9'($urandom_range(511)),
                              1'($urandom_range(1))));
        end
        send_word(mk_word(tts_pkg::REQ_TRIM, 8'd0, 1'b0, tts_pkg::DIR_STAY, 9'd0, 1'b0));
        send_word(mk_word(tts_pkg::REQ_STEP, 8'd0, 1'b0, tts_pkg::DIR_LEFT, 9'd0, 1'b0));
        drain_reports();

        random_phase(125);
        sender_idle_pct = 68;
        recv_stall_pct  = 0;
        random_phase(125);
        sender_idle_pct = 0;
        recv_stall_pct  = 68;
        random_phase(125);
        sender_idle_pct = 16;
        recv_stall_pct  = 16;
        random_phase(125);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && reports_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
